// File: src/rspf_pkg.sv
package rspf_pkg;

   localparam int MAX_SLOTS  = 8192;
   localparam int MAXP_MIN   = 100;
   localparam int COORD_W    = 32;
   localparam int COEF_W     = 18;
   localparam int NUM_AXES   = 3;
   localparam int ROW_W      = COEF_W * NUM_AXES;
   localparam int RSQ_W      = 63;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int MAXP_W     = 14;
   localparam int SLOT_W     = 13;
   localparam int CNT_W      = 32;
   localparam int BIT_IDX_W  = 5;
   localparam int PROD_W     = COORD_W + COEF_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = SUM_W - FRAC_W;
   localparam int ROUND_HALF = 32768;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 63;
   localparam int STATUS_W   = 3;

   localparam logic [ROW_W-1:0]         ROT_ROW0_RST   = ROW_W'(65536);
   localparam logic [ROW_W-1:0]         ROT_ROW1_RST   = ROW_W'(65536) << COEF_W;
   localparam logic [ROW_W-1:0]         ROT_ROW2_RST   = ROW_W'(65536) << (2 * COEF_W);
   localparam logic signed [COORD_W-1:0] HEIGHT_MIN_RST = -32'sd22938;
   localparam logic signed [COORD_W-1:0] HEIGHT_MAX_RST = 32'sd55706;
   localparam logic [RSQ_W-1:0]         MIN_RSQ_RST    = 63'd526133493;
   localparam logic [RSQ_W-1:0]         MAX_RSQ_RST    = 63'd618475290624;
   localparam logic [MAXP_W-1:0]        MAXP_RST       = 14'd8000;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_INVALID  = 3'd1,
      ST_HEIGHT   = 3'd2,
      ST_RANGE    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_ROW0     = 3'd0,
      CSR_ROT_ROW1     = 3'd1,
      CSR_ROT_ROW2     = 3'd2,
      CSR_HEIGHT_MIN   = 3'd3,
      CSR_HEIGHT_MAX   = 3'd4,
      CSR_MIN_RANGE_SQ = 3'd5,
      CSR_MAX_RANGE_SQ = 3'd6,
      CSR_MAX_POINTS   = 3'd7
   } csr_index_type;

   typedef struct packed {
      status_type                 status;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic                       first;
      logic                       last;
   } point_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][ROW_W-1:0] rot;
      logic [COORD_W-1:0]             height_min;
      logic [COORD_W-1:0]             height_max;
      logic [RSQ_W-1:0]               min_range_sq;
      logic [RSQ_W-1:0]               max_range_sq;
   } front_cfg_type;

endpackage

// File: src/rspf_front.sv
module rspf_front import rspf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [COORD_W-1:0] x_in,
   input  logic signed [COORD_W-1:0] y_in,
   input  logic signed [COORD_W-1:0] z_in,
   input  logic                      point_valid,
   input  logic                      first_of_cloud,
   input  logic                      last_of_cloud,
   input  front_cfg_type             cfg,
   output logic                      out_valid,
   input  logic                      out_ready,
   output point_type                 out_point
);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic                      advance;
   logic signed [COORD_W-1:0] coord [NUM_AXES];

   // stage 1: products
   logic signed [PROD_W-1:0]  prod_in [NUM_AXES][NUM_AXES];
   logic signed [PROD_W-1:0]  prod_ff [NUM_AXES][NUM_AXES];
   logic                      v1_ff, pv1_ff, first1_ff, last1_ff;

   // stage 2: rounded, saturated rotation
   logic signed [SUM_W-1:0]   sum [NUM_AXES];
   logic signed [Q_W-1:0]     quo [NUM_AXES];
   logic [Q_W-COORD_W:0]      upper [NUM_AXES];
   logic signed [COORD_W-1:0] rot_in [NUM_AXES];
   logic signed [COORD_W-1:0] rot_ff [NUM_AXES];
   logic                      v2_ff, pv2_ff, first2_ff, last2_ff;

   // stage 3: squares and height check
   logic [COORD_W-1:0]        mag_x, mag_y;
   logic [SQ_W-1:0]           sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic signed [COORD_W-1:0] hmin, hmax;
   logic                      hfail_in, hfail_ff;
   logic signed [COORD_W-1:0] rot3_ff [NUM_AXES];
   logic                      v3_ff, pv3_ff, first3_ff, last3_ff;

   // classification after stage 3
   logic [SQ_W-1:0]           r2;
   logic [RSQ_W-1:0]          r2_sat;
   logic                      rfail;

   assign advance  = !v3_ff || out_ready;
   assign in_ready = advance;

   assign coord[0] = x_in;
   assign coord[1] = y_in;
   assign coord[2] = z_in;

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            prod_in[r][c] = PROD_W'($signed(cfg.rot[r][COEF_W*c +: COEF_W]))
                            * PROD_W'(coord[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         sum[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                  + SUM_W'(prod_ff[r][2]) + SUM_W'(ROUND_HALF);
         quo[r] = sum[r][SUM_W-1:FRAC_W];
         upper[r] = quo[r][Q_W-1:COORD_W-1];
         if (!pv1_ff) begin
            rot_in[r] = '0;
         end else if ((&upper[r]) || !(|upper[r])) begin
            rot_in[r] = quo[r][COORD_W-1:0];
         end else if (quo[r][Q_W-1]) begin
            rot_in[r] = COORD_MIN;
         end else begin
            rot_in[r] = COORD_MAX;
         end
      end
   end

   assign mag_x    = rot_ff[0][COORD_W-1] ? (~rot_ff[0] + 1'b1) : rot_ff[0];
   assign mag_y    = rot_ff[1][COORD_W-1] ? (~rot_ff[1] + 1'b1) : rot_ff[1];
   assign sqx_in   = SQ_W'(mag_x) * SQ_W'(mag_x);
   assign sqy_in   = SQ_W'(mag_y) * SQ_W'(mag_y);
   assign hmin     = cfg.height_min;
   assign hmax     = cfg.height_max;
   assign hfail_in = (rot_ff[2] < hmin) || (rot_ff[2] > hmax);

   // each square is at most 2^62, so the sum cannot wrap in 64 bits
   assign r2     = sqx_ff + sqy_ff;
   assign r2_sat = r2[SQ_W-1] ? {RSQ_W{1'b1}} : r2[RSQ_W-1:0];
   assign rfail  = (r2_sat < cfg.min_range_sq) || (r2_sat > cfg.max_range_sq);

   always_comb begin
      out_point.x     = rot3_ff[0];
      out_point.y     = rot3_ff[1];
      out_point.z     = rot3_ff[2];
      out_point.first = first3_ff;
      out_point.last  = last3_ff;
      if (!pv3_ff) begin
         out_point.status = ST_INVALID;
      end else if (hfail_ff) begin
         out_point.status = ST_HEIGHT;
      end else if (rfail) begin
         out_point.status = ST_RANGE;
      end else begin
         out_point.status = ST_STORED;
      end
   end

   assign out_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         pv1_ff    <= point_valid;
         first1_ff <= first_of_cloud;
         last1_ff  <= last_of_cloud;
         rot_ff    <= rot_in;
         pv2_ff    <= pv1_ff;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         hfail_ff  <= hfail_in;
         rot3_ff   <= rot_ff;
         pv3_ff    <= pv2_ff;
         first3_ff <= first2_ff;
         last3_ff  <= last2_ff;
      end
   end

endmodule

// File: src/rspf_queue.sv
module rspf_queue import rspf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  point_type push_point,
   output logic      pop_valid,
   input  logic      pop_ready,
   output point_type pop_point
);

   point_type          entries_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_point  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign count_in   = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_point;
      end
   end

endmodule

// File: src/rspf_back.sv
module rspf_back import rspf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  point_type                 q_point,
   input  logic [MAXP_W-1:0]         mp,
   input  logic                      mp_load,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [MAXP_W-1:0]         rsp_stored_count,
   output logic                      rsp_cloud_done
);

   // res_ff tracks count_ff mod mp; rebuilt bit-serially after mp changes
   logic [CNT_W-1:0]     count_ff, count0, count1;
   logic [SLOT_W-1:0]    res_ff, res0, res1;
   logic [MAXP_W-1:0]    res_inc;
   status_type           status_in;
   logic [SLOT_W-1:0]    slot_in;
   logic [MAXP_W-1:0]    stored_in;

   logic                 div_busy_ff;
   logic [BIT_IDX_W-1:0] div_bit_ff;
   logic [SLOT_W-1:0]    div_rem_ff, div_rem_in;
   logic [MAXP_W-1:0]    div_shift;

   logic                 rsp_valid_ff;
   status_type           status_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [MAXP_W-1:0]    stored_ff;
   logic                 done_ff;

   assign q_pop = q_valid && !div_busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      count0    = q_point.first ? '0 : count_ff;
      res0      = q_point.first ? '0 : res_ff;
      res_inc   = {1'b0, res0} + 1'b1;
      count1    = count0;
      res1      = res0;
      status_in = q_point.status;
      slot_in   = '0;
      if (q_point.status == ST_STORED) begin
         if (count0 != '1) begin
            count1 = count0 + 1'b1;
            res1   = (res_inc == mp) ? '0 : res_inc[SLOT_W-1:0];
         end
         if (count1 <= CNT_W'(mp)) begin
            slot_in = SLOT_W'(count1 - 1'b1);
         end else if (res1 == '0) begin
            status_in = ST_OVERFLOW;
         end else begin
            slot_in = res1 - 1'b1;
         end
      end
      stored_in = (count1 < CNT_W'(mp)) ? MAXP_W'(count1) : mp;
   end

   assign div_shift  = {div_rem_ff, count_ff[div_bit_ff]};
   assign div_rem_in = (div_shift >= mp) ? SLOT_W'(div_shift - mp) : SLOT_W'(div_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         res_ff      <= '0;
         div_busy_ff <= 1'b0;
         div_bit_ff  <= '0;
         div_rem_ff  <= '0;
      end else if (mp_load) begin
         div_busy_ff <= 1'b1;
         div_bit_ff  <= '1;
         div_rem_ff  <= '0;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_rem_in;
         div_bit_ff <= div_bit_ff - 1'b1;
         if (div_bit_ff == '0) begin
            res_ff      <= div_rem_in;
            div_busy_ff <= 1'b0;
         end
      end else if (q_pop) begin
         count_ff <= count1;
         res_ff   <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         x_ff      <= q_point.x;
         y_ff      <= q_point.y;
         z_ff      <= q_point.z;
         stored_ff <= stored_in;
         done_ff   <= q_point.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_out_x        = x_ff;
   assign rsp_out_y        = y_ff;
   assign rsp_out_z        = z_ff;
   assign rsp_stored_count = stored_ff;
   assign rsp_cloud_done   = done_ff;

endmodule

// File: src/rotate_slice_point_filter_unit.sv
// Each result passes three front stages, the queue and the output register; rsp_ready stalls it.
// Throughput: one point per cycle unless stalled; product/round/square stages feed a 4-entry queue.
// Writing the slot-count register starts a bit-serial rebuild of the count residue;
// results wait until it finishes, while up to 7 transactions fill the front stages and queue.
// Reset (synchronous, active high): registers to defaults, count zero, queue and
// output register empty.
module rotate_slice_point_filter_unit import rspf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [COORD_W-1:0] req_z_in,
   input  logic                      req_point_valid,
   input  logic                      req_first_of_cloud,
   input  logic                      req_last_of_cloud,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [MAXP_W-1:0]         rsp_stored_count,
   output logic                      rsp_cloud_done,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic [ROW_W-1:0]   rot0_ff, rot1_ff, rot2_ff;
   logic [COORD_W-1:0] hmin_ff, hmax_ff;
   logic [RSQ_W-1:0]   minr_ff, maxr_ff;
   logic [MAXP_W-1:0]  maxp_ff;
   logic [MAXP_W-1:0]  mp_eff;
   logic               mp_load;
   front_cfg_type      front_cfg;

   logic               f_valid, f_ready, q_valid, q_pop;
   point_type          f_point, q_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff <= ROT_ROW0_RST;
         rot1_ff <= ROT_ROW1_RST;
         rot2_ff <= ROT_ROW2_RST;
         hmin_ff <= HEIGHT_MIN_RST;
         hmax_ff <= HEIGHT_MAX_RST;
         minr_ff <= MIN_RSQ_RST;
         maxr_ff <= MAX_RSQ_RST;
         maxp_ff <= MAXP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW0:     rot0_ff <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW1:     rot1_ff <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW2:     rot2_ff <= csr_wdata[ROW_W-1:0];
            CSR_HEIGHT_MIN:   hmin_ff <= csr_wdata[COORD_W-1:0];
            CSR_HEIGHT_MAX:   hmax_ff <= csr_wdata[COORD_W-1:0];
            CSR_MIN_RANGE_SQ: minr_ff <= csr_wdata[RSQ_W-1:0];
            CSR_MAX_RANGE_SQ: maxr_ff <= csr_wdata[RSQ_W-1:0];
            CSR_MAX_POINTS:   maxp_ff <= csr_wdata[MAXP_W-1:0];
            default: ;
         endcase
      end
   end

   assign mp_load = csr_we && (csr_index == CSR_MAX_POINTS);
   assign mp_eff  = (maxp_ff < MAXP_W'(MAXP_MIN))  ? MAXP_W'(MAXP_MIN)  :
                    (maxp_ff > MAXP_W'(MAX_SLOTS)) ? MAXP_W'(MAX_SLOTS) : maxp_ff;

   always_comb begin
      front_cfg.rot          = {rot2_ff, rot1_ff, rot0_ff};
      front_cfg.height_min   = hmin_ff;
      front_cfg.height_max   = hmax_ff;
      front_cfg.min_range_sq = minr_ff;
      front_cfg.max_range_sq = maxr_ff;
   end

   rspf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .x_in           (req_x_in),
      .y_in           (req_y_in),
      .z_in           (req_z_in),
      .point_valid    (req_point_valid),
      .first_of_cloud (req_first_of_cloud),
      .last_of_cloud  (req_last_of_cloud),
      .cfg            (front_cfg),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_point      (f_point)
   );

   rspf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_point (f_point),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_point  (q_point)
   );

   rspf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_point          (q_point),
      .mp               (mp_eff),
      .mp_load          (mp_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_stored_count (rsp_stored_count),
      .rsp_cloud_done   (rsp_cloud_done)
   );

   a_stored_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_STORED) |-> (MAXP_W'(rsp_slot) < rsp_stored_count))
      else $error("stored slot not below stored count");

   a_unstored_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_STORED) |-> (rsp_slot == '0))
      else $error("slot nonzero on unstored point");

   a_invalid_zero_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_INVALID)
      |-> (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0))
      else $error("invalid point carries nonzero coordinates");

   a_queue_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      (f_valid && !f_ready) |=> f_valid)
      else $error("front dropped a classified point while queue was full");

endmodule
